// ----- hdl/simd_rotate_unit_assert.svh -----
// Assertion macros used by the rotate unit RTL.
`ifndef SIMD_ROTATE_UNIT_ASSERT_SVH
`define SIMD_ROTATE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define SRU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SRU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SRU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SRU_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/srot_pkg.sv -----
package srot_pkg;

   localparam int VEC_W      = 128;
   localparam int HALF_VEC_W = VEC_W / 2;
   localparam int CMD_W      = 4;
   localparam int IMM_W      = 7;

   localparam int HW_W       = 16;
   localparam int HW_CNT_W   = 4;
   localparam int HW_LANES   = VEC_W / HW_W;

   localparam int WD_W       = 32;
   localparam int WD_CNT_W   = 5;
   localparam int WD_LANES   = VEC_W / WD_W;

   // Quadword rotate amount in bits, 0 to 127.
   localparam int QCNT_W     = 7;
   localparam int QBIT_CNT_W = 3;
   localparam int QBYTE_CNT_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_ROTH         = 4'd0,
      CMD_ROTHI        = 4'd1,
      CMD_ROT          = 4'd2,
      CMD_ROTI         = 4'd3,
      CMD_QBIT_IMM     = 4'd4,
      CMD_QBIT_REG     = 4'd5,
      CMD_QBYTE_REG    = 4'd6,
      CMD_QBYTE_IMM    = 4'd7,
      CMD_QBYTE_BITCNT = 4'd8
   } command_type;

   typedef struct packed {
      logic                word_mode;
      logic                use_imm;
      logic [WD_CNT_W-1:0] imm_count;
   } lane_ctrl_type;

endpackage

// ----- hdl/srot_if.sv -----
interface srot_req_if;
   logic                          valid;
   logic                          ready;
   logic [srot_pkg::CMD_W-1:0]      command;
   logic [srot_pkg::HALF_VEC_W-1:0] operand_a_low;
   logic [srot_pkg::HALF_VEC_W-1:0] operand_a_high;
   logic [srot_pkg::HALF_VEC_W-1:0] operand_b_low;
   logic [srot_pkg::HALF_VEC_W-1:0] operand_b_high;
   logic [srot_pkg::IMM_W-1:0]      immediate;

   modport source (
      output valid, command, operand_a_low, operand_a_high,
             operand_b_low, operand_b_high, immediate,
      input  ready
   );
   modport sink (
      input  valid, command, operand_a_low, operand_a_high,
             operand_b_low, operand_b_high, immediate,
      output ready
   );
endinterface

interface srot_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srot_pkg::HALF_VEC_W-1:0] result_low;
   logic [srot_pkg::HALF_VEC_W-1:0] result_high;

   modport source (
      output valid, result_low, result_high,
      input  ready
   );
   modport sink (
      input  valid, result_low, result_high,
      output ready
   );
endinterface

// ----- hdl/simd_rotate_unit.sv -----
// Rotate unit for a 128-bit SIMD register: per-lane halfword and word rotates
// and whole-quadword bit and byte rotates of operand A, with the count taken
// from B's lanes, B's preferred word (bits 127:96) or the immediate. A
// request is taken into an input register, rotated in one combinational pass
// of shift muxes and written to the result register, which offers it to the
// consumer; one request can be taken every cycle while the consumer is not
// stalling. The input register frees itself whenever the result register can
// load; while a result waits on a stalled consumer the input register holds
// one further request and then ready drops until the result drains. A count
// of zero and an unknown command both return A unchanged.
`include "simd_rotate_unit_assert.svh"

module simd_rotate_unit (
   input logic      clock,
   input logic      reset,
   srot_req_if.sink   req,
   srot_rsp_if.source rsp
);
   import srot_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   command_type      cmd_ff;
   logic [VEC_W-1:0] a_ff;
   logic [VEC_W-1:0] b_ff;
   logic [IMM_W-1:0] imm_ff;
   logic [VEC_W-1:0] res_ff, res_in;

   logic             req_ready;
   logic             req_take;
   logic             out_load;

   logic [WD_W-1:0]   pref;
   lane_ctrl_type     lane_ctrl;
   logic [QCNT_W-1:0] qcount;
   logic [VEC_W-1:0]  lane_res;
   logic [VEC_W-1:0]  quad_res;

   // Handshake: advance the result register when it is empty or being drained.
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req_ready = !in_valid_ff || out_load;
   assign req_take  = req.valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= command_type'(req.command);
         a_ff   <= {req.operand_a_high, req.operand_a_low};
         b_ff   <= {req.operand_b_high, req.operand_b_low};
         imm_ff <= req.immediate;
      end
      if (out_load) begin
         res_ff <= res_in;
      end
   end

   // Count decode.
   assign pref = b_ff[VEC_W-1 -: WD_W];

   assign lane_ctrl.word_mode = (cmd_ff == CMD_ROT) || (cmd_ff == CMD_ROTI);
   assign lane_ctrl.use_imm   = (cmd_ff == CMD_ROTHI) || (cmd_ff == CMD_ROTI);
   assign lane_ctrl.imm_count = imm_ff[WD_CNT_W-1:0];

   always_comb begin
      unique case (cmd_ff)
         CMD_QBIT_IMM:
            qcount = {{(QCNT_W-QBIT_CNT_W){1'b0}}, imm_ff[QBIT_CNT_W-1:0]};
         CMD_QBIT_REG:
            qcount = {{(QCNT_W-QBIT_CNT_W){1'b0}}, pref[QBIT_CNT_W-1:0]};
         CMD_QBYTE_REG:
            qcount = {pref[QBYTE_CNT_W-1:0], {QBIT_CNT_W{1'b0}}};
         CMD_QBYTE_IMM:
            qcount = {imm_ff[QBYTE_CNT_W-1:0], {QBIT_CNT_W{1'b0}}};
         CMD_QBYTE_BITCNT:
            qcount = {pref[QBIT_CNT_W +: QBYTE_CNT_W], {QBIT_CNT_W{1'b0}}};
         default:
            qcount = '0;
      endcase
   end

   srot_lane_rotate u_lane (
      .a      (a_ff),
      .b      (b_ff),
      .ctrl   (lane_ctrl),
      .result (lane_res)
   );

   srot_quad_rotate u_quad (
      .a      (a_ff),
      .count  (qcount),
      .result (quad_res)
   );

   always_comb begin
      case (cmd_ff) inside
         CMD_ROTH, CMD_ROTHI, CMD_ROT, CMD_ROTI:
            res_in = lane_res;
         CMD_QBIT_IMM, CMD_QBIT_REG, CMD_QBYTE_REG, CMD_QBYTE_IMM, CMD_QBYTE_BITCNT:
            res_in = quad_res;
         default:
            res_in = a_ff;
      endcase
   end

   assign req.ready       = req_ready;
   assign rsp.valid       = out_valid_ff;
   assign rsp.result_low  = res_ff[HALF_VEC_W-1:0];
   assign rsp.result_high = res_ff[VEC_W-1:HALF_VEC_W];

   `SRU_ASSERT_NXT(a_req_lands, clock, reset, req_take, in_valid_ff)
   `SRU_ASSERT_NXT(a_in_held, clock, reset, in_valid_ff && !out_load, in_valid_ff)
   `SRU_ASSERT_NXT(a_out_loads, clock, reset, out_load, out_valid_ff)
   `SRU_ASSERT_NXT(a_no_repeat, clock, reset, out_valid_ff && rsp.ready && !out_load, !out_valid_ff)
   `SRU_ASSERT_NXT(a_unknown_pass, clock, reset, out_load && (cmd_ff > CMD_QBYTE_BITCNT), res_ff == $past(a_ff))

endmodule

// ----- hdl/srot_lane_rotate.sv -----
module srot_lane_rotate (
   input  logic [srot_pkg::VEC_W-1:0] a,
   input  logic [srot_pkg::VEC_W-1:0] b,
   input  srot_pkg::lane_ctrl_type    ctrl,
   output logic [srot_pkg::VEC_W-1:0] result
);
   import srot_pkg::*;

   logic [VEC_W-1:0] hw_res;
   logic [VEC_W-1:0] wd_res;

   // Rotate by shifting a doubled lane and keeping the upper copy.
   for (genvar i = 0; i < HW_LANES; i++) begin : g_hw
      logic [HW_CNT_W-1:0] n;
      logic [2*HW_W-1:0]   dbl;
      assign n   = ctrl.use_imm ? ctrl.imm_count[HW_CNT_W-1:0] : b[HW_W*i +: HW_CNT_W];
      assign dbl = {a[HW_W*i +: HW_W], a[HW_W*i +: HW_W]} << n;
      assign hw_res[HW_W*i +: HW_W] = dbl[2*HW_W-1:HW_W];
   end

   for (genvar i = 0; i < WD_LANES; i++) begin : g_wd
      logic [WD_CNT_W-1:0] n;
      logic [2*WD_W-1:0]   dbl;
      assign n   = ctrl.use_imm ? ctrl.imm_count : b[WD_W*i +: WD_CNT_W];
      assign dbl = {a[WD_W*i +: WD_W], a[WD_W*i +: WD_W]} << n;
      assign wd_res[WD_W*i +: WD_W] = dbl[2*WD_W-1:WD_W];
   end

   assign result = ctrl.word_mode ? wd_res : hw_res;

endmodule

// ----- hdl/srot_quad_rotate.sv -----
module srot_quad_rotate (
   input  logic [srot_pkg::VEC_W-1:0]  a,
   input  logic [srot_pkg::QCNT_W-1:0] count,
   output logic [srot_pkg::VEC_W-1:0]  result
);
   import srot_pkg::*;

   logic [2*VEC_W-1:0] dbl;

   assign dbl    = {a, a} << count;
   assign result = dbl[2*VEC_W-1:VEC_W];

endmodule
